>>> sv/jdc_pkg.sv
// Shared constants and the month-offset table for the Julian Date converter.
`default_nettype none

package jdc_pkg;

    localparam int unsigned GREGORIAN_START = 2299161;
    localparam int unsigned ALPHA_BIAS      = 7468865;
    localparam int unsigned ALPHA_DIV       = 146097;
    localparam int unsigned B_OFFSET_JUL    = 1524;
    localparam int unsigned B_OFFSET_GREG   = 1525;
    localparam int unsigned C_BIAS          = 2442;
    localparam int unsigned C_DIV           = 7305;
    localparam int unsigned D_MUL           = 1461;
    localparam int unsigned E_MUL           = 10000;
    localparam int unsigned E_DIV           = 306001;
    localparam int unsigned YEAR_LATE       = 4716;
    localparam int unsigned YEAR_EARLY      = 4715;
    localparam int unsigned MS_PER_DAY      = 86400000;
    localparam int unsigned MS_PER_HOUR     = 3600000;
    localparam int unsigned MS_PER_MIN      = 60000;
    localparam int unsigned MS_PER_SEC      = 1000;
    localparam int unsigned MONTH_WRAP      = 14;
    localparam int unsigned MONTH_FEB       = 2;

    localparam int MS_W   = 27;
    localparam int BD_W   = 9;
    localparam int E_W    = 4;
    localparam int YEAR_W = 16;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int MSEC_W = 10;

    function automatic logic [BD_W-1:0] month_offset(input logic [E_W-1:0] e);
        logic [BD_W-1:0] v;
        case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            4'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/jdc_cdiv.sv
// Four-stage pipelined exact division by a constant through a reciprocal multiply.
`default_nettype none

module jdc_cdiv #(
    parameter int NUM_W  = 34,
    parameter int DEN    = 146097,
    parameter int Q_W    = 17,
    parameter int R_W    = 18,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [Q_W-1:0]         o_quo,
    output logic [R_W-1:0]         o_rem,
    output logic [SIDE_W-1:0]      o_side
);

    localparam longint unsigned MUL = (64'd1 << NUM_W) / DEN;
    localparam int MUL_W = $clog2(MUL + 1);
    localparam int P_W   = NUM_W + MUL_W;
    localparam int R0_W  = R_W + 1;
    localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL);
    localparam logic [NUM_W-1:0] DEN_N = NUM_W'(DEN);
    localparam logic [R0_W-1:0]  DEN_R = R0_W'(DEN);

    logic [3:0]        r_v;
    logic [3:0]        stl;
    logic [3:0]        ld;
    logic [NUM_W-1:0]  r_num0;
    logic [SIDE_W-1:0] r_side0;
    logic [NUM_W-1:0]  r_num1;
    logic [Q_W-1:0]    r_q1;
    logic [SIDE_W-1:0] r_side1;
    logic [R0_W-1:0]   r_rem2;
    logic [Q_W-1:0]    r_q2;
    logic [SIDE_W-1:0] r_side2;
    logic [Q_W-1:0]    r_q3;
    logic [R_W-1:0]    r_rem3;
    logic [SIDE_W-1:0] r_side3;
    logic [P_W-1:0]    prod;
    logic [Q_W-1:0]    n_q1;
    logic [NUM_W-1:0]  back;
    logic [R0_W-1:0]   n_rem2;

    always_comb begin
        stl[3] = i_stall;
        for (int k = 2; k >= 0; k--) begin
            stl[k] = r_v[k+1] && stl[k+1];
        end
        ld = ~(r_v & stl);
    end

    assign prod   = P_W'(r_num0) * P_W'(MUL_C);
    assign n_q1   = Q_W'(prod >> NUM_W);
    assign back   = NUM_W'(NUM_W'(r_q1) * DEN_N);
    assign n_rem2 = R0_W'(r_num1 - back);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < 4; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_num0  <= i_num;
            r_side0 <= i_side;
        end
        if (ld[1]) begin
            r_num1  <= r_num0;
            r_q1    <= n_q1;
            r_side1 <= r_side0;
        end
        if (ld[2]) begin
            r_rem2  <= n_rem2;
            r_q2    <= r_q1;
            r_side2 <= r_side1;
        end
        if (ld[3]) begin
            r_side3 <= r_side2;
            if (r_rem2 >= DEN_R) begin
                r_q3   <= r_q2 + Q_W'(1);
                r_rem3 <= R_W'(r_rem2 - DEN_R);
            end else begin
                r_q3   <= r_q2;
                r_rem3 <= R_W'(r_rem2);
            end
        end
    end

    assign o_stall = r_v[0] && stl[0];
    assign o_valid = r_v[3];
    assign o_quo   = r_q3;
    assign o_rem   = r_rem3;
    assign o_side  = r_side3;

endmodule

`default_nettype wire

>>> sv/julian_date_to_calendar_time.sv
// Top level of the Julian Date to calendar date and time-of-day converter.
//
// Input channel: i_valid, o_stall and i_julian_date, an unsigned fixed-point
// Julian Date with DAY_BITS integer and FRACTION_BITS fraction bits. A
// transaction is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall and the year, month, day, hour, minute,
// second and millisecond fields; a transaction completes with o_valid high
// and i_stall low.
// One transaction is taken every cycle while o_stall is low. The depth is
// set by six constant dividers of four stages each, chained along the date
// and then the time-of-day path, plus six single register stages.
// When the receiver stalls, each stage holds its item and bubbles in front
// of it are filled; o_stall rises once the whole pipeline is full.
// Synchronous reset clears every stage valid bit, and nothing in flight is
// delivered afterwards.
`default_nettype none

module julian_date_to_calendar_time #(
    parameter int DAY_BITS      = 23,
    parameter int FRACTION_BITS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [DAY_BITS+FRACTION_BITS-1:0]  i_julian_date,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [jdc_pkg::YEAR_W-1:0]       o_year,
    output logic [jdc_pkg::MON_W-1:0]               o_month,
    output logic [jdc_pkg::DAY_W-1:0]               o_day_of_month,
    output logic [jdc_pkg::HOUR_W-1:0]              o_hour,
    output logic [jdc_pkg::MIN_W-1:0]               o_minute,
    output logic [jdc_pkg::SEC_W-1:0]               o_second,
    output logic [jdc_pkg::MSEC_W-1:0]              o_millisecond
);

    localparam int JD_W  = DAY_BITS + FRACTION_BITS;
    localparam int Z_W   = DAY_BITS + 1;
    localparam int NA_W  = Z_W + 2;
    localparam int AQ_W  = NA_W - $clog2(jdc_pkg::ALPHA_DIV) + 1;
    localparam int AR_W  = $clog2(jdc_pkg::ALPHA_DIV);
    localparam int B_W   = Z_W + 1;
    localparam int NC_W  = B_W + 5;
    localparam int CQ_W  = NC_W - $clog2(jdc_pkg::C_DIV) + 1;
    localparam int CR_W  = $clog2(jdc_pkg::C_DIV);
    localparam int DP_W  = CQ_W + 11;
    localparam int NE_W  = 23;
    localparam int EQ_W  = NE_W - $clog2(jdc_pkg::E_DIV) + 1;
    localparam int ER_W  = $clog2(jdc_pkg::E_DIV);
    localparam int MS_W  = jdc_pkg::MS_W;
    localparam int BD_W  = jdc_pkg::BD_W;
    localparam int FP_W  = FRACTION_BITS + MS_W;
    localparam int HQ_W  = MS_W - $clog2(jdc_pkg::MS_PER_HOUR) + 1;
    localparam int HR_W  = $clog2(jdc_pkg::MS_PER_HOUR);
    localparam int MQ_W  = HR_W - $clog2(jdc_pkg::MS_PER_MIN) + 1;
    localparam int MR_W  = $clog2(jdc_pkg::MS_PER_MIN);
    localparam int SQ_W  = MR_W - $clog2(jdc_pkg::MS_PER_SEC) + 1;
    localparam int SR_W  = $clog2(jdc_pkg::MS_PER_SEC);
    localparam int DATE_W = jdc_pkg::YEAR_W + jdc_pkg::MON_W + jdc_pkg::DAY_W;
    localparam int SA_W  = Z_W + 1 + MS_W;
    localparam int SC_W  = B_W + MS_W;
    localparam int SE_W  = CQ_W + BD_W + MS_W;
    localparam int SM_W  = DATE_W + jdc_pkg::HOUR_W;
    localparam int SS_W  = SM_W + jdc_pkg::MIN_W;
    localparam logic [JD_W:0] HALF_DAY = (JD_W+1)'(1) << (FRACTION_BITS - 1);

    // Front stages.
    logic                     r_s0_v;
    logic [Z_W-1:0]           r_s0_z;
    logic [FRACTION_BITS-1:0] r_s0_f;
    logic                     r_s1_v;
    logic [Z_W-1:0]           r_s1_z;
    logic                     r_s1_greg;
    logic [NA_W-1:0]          r_s1_na;
    logic [MS_W-1:0]          r_s1_ms;
    logic [JD_W:0]            jd_sum;
    logic [FP_W-1:0]          f_prod;
    logic                     n_greg;
    logic                     s0_stall;
    logic                     s1_stall;

    // Alpha divider.
    logic                     da_stall;
    logic                     da_valid;
    logic [AQ_W-1:0]          da_quo;
    logic [SA_W-1:0]          da_side;
    logic [Z_W-1:0]           da_z;
    logic                     da_greg;
    logic [MS_W-1:0]          da_ms;

    logic                     r_s2_v;
    logic [B_W-1:0]           r_s2_b;
    logic [MS_W-1:0]          r_s2_ms;
    logic                     s2_stall;
    logic [NC_W-1:0]          nc;

    // Year divider.
    logic                     dc_stall;
    logic                     dc_valid;
    logic [CQ_W-1:0]          dc_quo;
    logic [SC_W-1:0]          dc_side;

    logic                     r_s4_v;
    logic [B_W-1:0]           r_s4_b;
    logic [B_W-1:0]           r_s4_d;
    logic [CQ_W-1:0]          r_s4_c;
    logic [MS_W-1:0]          r_s4_ms;
    logic [DP_W-1:0]          d_prod;
    logic                     s4_stall;
    logic                     r_s5_v;
    logic [CQ_W-1:0]          r_s5_c;
    logic [BD_W-1:0]          r_s5_bd;
    logic [MS_W-1:0]          r_s5_ms;
    logic                     s5_stall;

    // Month divider.
    logic                     de_stall;
    logic                     de_valid;
    logic [EQ_W-1:0]          de_quo;
    logic [SE_W-1:0]          de_side;
    logic [CQ_W-1:0]          de_c;
    logic [BD_W-1:0]          de_bd;
    logic [MS_W-1:0]          de_ms;
    logic [jdc_pkg::E_W-1:0]  de_e;
    logic [jdc_pkg::MON_W-1:0] n_month;

    logic                     r_s6_v;
    logic [DATE_W-1:0]        r_s6_date;
    logic [MS_W-1:0]          r_s6_ms;
    logic                     s6_stall;

    // Time-of-day dividers.
    logic                     dh_stall;
    logic                     dh_valid;
    logic [HQ_W-1:0]          dh_quo;
    logic [HR_W-1:0]          dh_rem;
    logic [DATE_W-1:0]        dh_side;
    logic                     dm_stall;
    logic                     dm_valid;
    logic [MQ_W-1:0]          dm_quo;
    logic [MR_W-1:0]          dm_rem;
    logic [SM_W-1:0]          dm_side;
    logic                     ds_stall_w;
    logic [SQ_W-1:0]          ds_quo;
    logic [SR_W-1:0]          ds_rem;
    logic [SS_W-1:0]          ds_side;

    assign jd_sum   = (JD_W+1)'(i_julian_date) + HALF_DAY;
    assign f_prod   = FP_W'(r_s0_f) * FP_W'(jdc_pkg::MS_PER_DAY);
    assign n_greg   = r_s0_z >= Z_W'(jdc_pkg::GREGORIAN_START);

    assign s1_stall = r_s1_v && da_stall;
    assign s0_stall = r_s0_v && s1_stall;
    assign o_stall  = s0_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            if (!s0_stall) begin
                r_s0_v <= i_valid;
            end
            if (!s1_stall) begin
                r_s1_v <= r_s0_v;
            end
            if (!s2_stall) begin
                r_s2_v <= da_valid;
            end
            if (!s4_stall) begin
                r_s4_v <= dc_valid;
            end
            if (!s5_stall) begin
                r_s5_v <= r_s4_v;
            end
            if (!s6_stall) begin
                r_s6_v <= de_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s0_stall) begin
            r_s0_z <= jd_sum[JD_W -: Z_W];
            r_s0_f <= jd_sum[FRACTION_BITS-1:0];
        end
        if (!s1_stall) begin
            r_s1_z    <= r_s0_z;
            r_s1_greg <= n_greg;
            r_s1_ms   <= MS_W'(f_prod >> FRACTION_BITS);
            if (n_greg) begin
                r_s1_na <= (NA_W'(r_s0_z) << 2) - NA_W'(jdc_pkg::ALPHA_BIAS);
            end else begin
                r_s1_na <= '0;
            end
        end
    end

    jdc_cdiv #(
        .NUM_W  (NA_W),
        .DEN    (jdc_pkg::ALPHA_DIV),
        .Q_W    (AQ_W),
        .R_W    (AR_W),
        .SIDE_W (SA_W)
    ) u_div_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_v),
        .o_stall (da_stall),
        .i_num   (r_s1_na),
        .i_side  ({r_s1_z, r_s1_greg, r_s1_ms}),
        .o_valid (da_valid),
        .i_stall (s2_stall),
        .o_quo   (da_quo),
        .o_rem   (),
        .o_side  (da_side)
    );

    assign {da_z, da_greg, da_ms} = da_side;
    assign s2_stall = r_s2_v && dc_stall;

    always_ff @(posedge i_clk) begin
        if (!s2_stall) begin
            r_s2_ms <= da_ms;
            if (da_greg) begin
                r_s2_b <= B_W'(da_z) + B_W'(jdc_pkg::B_OFFSET_GREG) + B_W'(da_quo)
                          - B_W'(da_quo >> 2);
            end else begin
                r_s2_b <= B_W'(da_z) + B_W'(jdc_pkg::B_OFFSET_JUL);
            end
        end
    end

    assign nc = (NC_W'(r_s2_b) << 4) + (NC_W'(r_s2_b) << 2) - NC_W'(jdc_pkg::C_BIAS);

    jdc_cdiv #(
        .NUM_W  (NC_W),
        .DEN    (jdc_pkg::C_DIV),
        .Q_W    (CQ_W),
        .R_W    (CR_W),
        .SIDE_W (SC_W)
    ) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .o_stall (dc_stall),
        .i_num   (nc),
        .i_side  ({r_s2_b, r_s2_ms}),
        .o_valid (dc_valid),
        .i_stall (s4_stall),
        .o_quo   (dc_quo),
        .o_rem   (),
        .o_side  (dc_side)
    );

    assign d_prod   = DP_W'(dc_quo) * DP_W'(jdc_pkg::D_MUL);
    assign s5_stall = r_s5_v && de_stall;
    assign s4_stall = r_s4_v && s5_stall;

    always_ff @(posedge i_clk) begin
        if (!s4_stall) begin
            r_s4_b  <= dc_side[SC_W-1 -: B_W];
            r_s4_ms <= dc_side[MS_W-1:0];
            r_s4_c  <= dc_quo;
            r_s4_d  <= B_W'(d_prod >> 2);
        end
        if (!s5_stall) begin
            r_s5_c  <= r_s4_c;
            r_s5_ms <= r_s4_ms;
            r_s5_bd <= BD_W'(r_s4_b - r_s4_d);
        end
    end

    jdc_cdiv #(
        .NUM_W  (NE_W),
        .DEN    (jdc_pkg::E_DIV),
        .Q_W    (EQ_W),
        .R_W    (ER_W),
        .SIDE_W (SE_W)
    ) u_div_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s5_v),
        .o_stall (de_stall),
        .i_num   (NE_W'(NE_W'(r_s5_bd) * NE_W'(jdc_pkg::E_MUL))),
        .i_side  ({r_s5_c, r_s5_bd, r_s5_ms}),
        .o_valid (de_valid),
        .i_stall (s6_stall),
        .o_quo   (de_quo),
        .o_rem   (),
        .o_side  (de_side)
    );

    assign {de_c, de_bd, de_ms} = de_side;
    assign de_e     = jdc_pkg::E_W'(de_quo);
    assign s6_stall = r_s6_v && dh_stall;

    always_comb begin
        if (de_e < jdc_pkg::E_W'(jdc_pkg::MONTH_WRAP)) begin
            n_month = de_e - jdc_pkg::MON_W'(1);
        end else begin
            n_month = de_e - jdc_pkg::MON_W'(13);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s6_stall) begin
            r_s6_ms <= de_ms;
            r_s6_date[jdc_pkg::DAY_W-1:0] <=
                jdc_pkg::DAY_W'(de_bd - jdc_pkg::month_offset(de_e));
            r_s6_date[jdc_pkg::DAY_W +: jdc_pkg::MON_W] <= n_month;
            if (n_month > jdc_pkg::MON_W'(jdc_pkg::MONTH_FEB)) begin
                r_s6_date[DATE_W-1 -: jdc_pkg::YEAR_W] <=
                    jdc_pkg::YEAR_W'(de_c) - jdc_pkg::YEAR_W'(jdc_pkg::YEAR_LATE);
            end else begin
                r_s6_date[DATE_W-1 -: jdc_pkg::YEAR_W] <=
                    jdc_pkg::YEAR_W'(de_c) - jdc_pkg::YEAR_W'(jdc_pkg::YEAR_EARLY);
            end
        end
    end

    jdc_cdiv #(
        .NUM_W  (MS_W),
        .DEN    (jdc_pkg::MS_PER_HOUR),
        .Q_W    (HQ_W),
        .R_W    (HR_W),
        .SIDE_W (DATE_W)
    ) u_div_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s6_v),
        .o_stall (dh_stall),
        .i_num   (r_s6_ms),
        .i_side  (r_s6_date),
        .o_valid (dh_valid),
        .i_stall (dm_stall),
        .o_quo   (dh_quo),
        .o_rem   (dh_rem),
        .o_side  (dh_side)
    );

    jdc_cdiv #(
        .NUM_W  (HR_W),
        .DEN    (jdc_pkg::MS_PER_MIN),
        .Q_W    (MQ_W),
        .R_W    (MR_W),
        .SIDE_W (SM_W)
    ) u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dh_valid),
        .o_stall (dm_stall),
        .i_num   (dh_rem),
        .i_side  ({dh_side, jdc_pkg::HOUR_W'(dh_quo)}),
        .o_valid (dm_valid),
        .i_stall (ds_stall_w),
        .o_quo   (dm_quo),
        .o_rem   (dm_rem),
        .o_side  (dm_side)
    );

    jdc_cdiv #(
        .NUM_W  (MR_W),
        .DEN    (jdc_pkg::MS_PER_SEC),
        .Q_W    (SQ_W),
        .R_W    (SR_W),
        .SIDE_W (SS_W)
    ) u_div_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dm_valid),
        .o_stall (ds_stall_w),
        .i_num   (dm_rem),
        .i_side  ({dm_side, jdc_pkg::MIN_W'(dm_quo)}),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_quo   (ds_quo),
        .o_rem   (ds_rem),
        .o_side  (ds_side)
    );

    assign o_year         = ds_side[SS_W-1 -: jdc_pkg::YEAR_W];
    assign o_month        = ds_side[SS_W-jdc_pkg::YEAR_W-1 -: jdc_pkg::MON_W];
    assign o_day_of_month = ds_side[SS_W-jdc_pkg::YEAR_W-jdc_pkg::MON_W-1 -: jdc_pkg::DAY_W];
    assign o_hour         = ds_side[jdc_pkg::MIN_W +: jdc_pkg::HOUR_W];
    assign o_minute       = ds_side[jdc_pkg::MIN_W-1:0];
    assign o_second       = jdc_pkg::SEC_W'(ds_quo);
    assign o_millisecond  = ds_rem;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the Julian Date to calendar time converter.
`timescale 1ns / 1ps

module testbench;

    localparam int DAY_BITS      = 23;
    localparam int FRACTION_BITS = 32;
    localparam int JD_W          = DAY_BITS + FRACTION_BITS;
    localparam int WATCHDOG      = 20000;
    localparam int RANDOM_ITEMS  = 650;

    typedef struct packed {
        logic signed [jdc_pkg::YEAR_W-1:0] year;
        logic [jdc_pkg::MON_W-1:0]         month;
        logic [jdc_pkg::DAY_W-1:0]         day;
        logic [jdc_pkg::HOUR_W-1:0]        hour;
        logic [jdc_pkg::MIN_W-1:0]         minute;
        logic [jdc_pkg::SEC_W-1:0]         second;
        logic [jdc_pkg::MSEC_W-1:0]        msec;
    } t_cal_time;

    class calendar_scoreboard;
        t_cal_time pending[$];
        int        mismatches;
        int        checked;

        function t_cal_time convert(logic [JD_W-1:0] jd);
            t_cal_time   r;
            logic [63:0] sum, z, f, a, b, c, d, e, alpha, mon, ms;
            longint      yr;
            sum = 64'(jd) + (64'd1 << (FRACTION_BITS - 1));
            z = sum >> FRACTION_BITS;
            f = sum & ((64'd1 << FRACTION_BITS) - 1);
            if (z < jdc_pkg::GREGORIAN_START) begin
                a = z;
            end else begin
                alpha = (4 * z - jdc_pkg::ALPHA_BIAS) / jdc_pkg::ALPHA_DIV;
                a = z + 1 + alpha - alpha / 4;
            end
            b = a + jdc_pkg::B_OFFSET_JUL;
            c = (20 * b - jdc_pkg::C_BIAS) / jdc_pkg::C_DIV;
            d = (jdc_pkg::D_MUL * c) / 4;
            e = (jdc_pkg::E_MUL * (b - d)) / jdc_pkg::E_DIV;
            r.day = jdc_pkg::DAY_W'(b - d - (jdc_pkg::E_DIV * e) / jdc_pkg::E_MUL);
            mon = (e < jdc_pkg::MONTH_WRAP) ? e - 1 : e - 13;
            yr = longint'(c) - ((mon > jdc_pkg::MONTH_FEB) ? jdc_pkg::YEAR_LATE
                                                            : jdc_pkg::YEAR_EARLY);
            ms = (f * jdc_pkg::MS_PER_DAY) >> FRACTION_BITS;
            r.year = jdc_pkg::YEAR_W'(yr);
            r.month = jdc_pkg::MON_W'(mon);
            r.hour = jdc_pkg::HOUR_W'(ms / jdc_pkg::MS_PER_HOUR);
            r.minute = jdc_pkg::MIN_W'((ms / jdc_pkg::MS_PER_MIN) % 60);
            r.second = jdc_pkg::SEC_W'((ms / jdc_pkg::MS_PER_SEC) % 60);
            r.msec = jdc_pkg::MSEC_W'(ms % jdc_pkg::MS_PER_SEC);
            return r;
        endfunction

        function void note_input(logic [JD_W-1:0] jd);
            pending.push_back(convert(jd));
        endfunction

        function void check_result(t_cal_time got);
            t_cal_time want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected transaction: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_stall = 1'b0;
    logic [JD_W-1:0] i_julian_date = '0;
    logic            o_stall, o_valid;
    wire t_cal_time  result;

    calendar_scoreboard sb = new();
    int  idle_pct = 27;
    int  quiet_cycles = 0;
    int  accepted = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    julian_date_to_calendar_time #(
        .DAY_BITS(DAY_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_julian_date(i_julian_date),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_year(result.year),
        .o_month(result.month),
        .o_day_of_month(result.day),
        .o_hour(result.hour),
        .o_minute(result.minute),
        .o_second(result.second),
        .o_millisecond(result.msec)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(result);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_date(logic [JD_W-1:0] jd);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_julian_date <= jd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(jd);
        accepted++;
    endtask

    function automatic logic [JD_W-1:0] day_and_fraction(longint unsigned day,
                                                         logic [31:0] frac);
        return JD_W'((day << FRACTION_BITS) | frac);
    endfunction

    function automatic logic [JD_W-1:0] random_date();
        logic [JD_W-1:0] v;
        int sel;
        sel = $urandom_range(9);
        v = JD_W'({$urandom, $urandom});
        if (sel < 3)
            v = day_and_fraction($urandom_range(2299161 + 400, 2299161 - 400), v[31:0]);
        else if (sel < 6)
            v = day_and_fraction($urandom_range(2470000, 2400000), v[31:0]);
        else if (sel == 6)
            v = day_and_fraction($urandom_range(2299161 - 1, 2299161 - 2) + 0, 32'hFFFF_FFFF - $urandom_range(3));
        return v;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_date('0);
        send_date({JD_W{1'b1}});
        send_date(day_and_fraction(0, 32'h8000_0000));
        send_date(day_and_fraction(0, 32'h7FFF_FFFF));
        send_date(day_and_fraction(2299160, 32'h7FFF_FFFF));
        send_date(day_and_fraction(2299160, 32'h8000_0000));
        send_date(day_and_fraction(2299161, 32'h0));
        send_date(day_and_fraction(2451544, 32'h8000_0000));
        send_date(day_and_fraction(2451604, 32'h8000_0000));
        send_date(day_and_fraction(2451605, 32'h8000_0000));
        send_date(day_and_fraction(2451910, 32'h7FFF_FFFF));
        send_date(day_and_fraction(2460000, 32'hFFFF_FFFF));
        send_date(day_and_fraction(8388607, 32'h8000_0000));
        send_date(day_and_fraction(8388607, 32'h0));
        send_date(day_and_fraction(1721423, 32'h5555_5555));
        send_date(day_and_fraction(1000000, 32'hAAAA_AAAA));
        i_valid <= 1'b0;

        // Hold off until the pipeline drains completely.
        wait (sb.pending.size() == 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_pct = (i >= 200 && i < 350) ? 0 : 27;
            send_date(random_date());
        end
        i_valid <= 1'b0;

        wait (sb.pending.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("Converted %0d Julian Dates across both calendars, day and range edges,",
                 accepted);
        $display("with random stalls on both sides; %0d results checked.", sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
